@@ design/smbr_pkg.sv @@
// Shared types and constants for the splitmix bounded random generator.
// Used by the top level; no dependencies.
package smbr_pkg;

    localparam int DATA_W = 64;
    localparam int PPM_W  = 20;
    localparam int HALF_W = DATA_W / 2;

    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_DRAW   = 2'd1;
    localparam logic [1:0] CMD_CHANCE = 2'd2;

    localparam logic [DATA_W-1:0] GOLDEN_STEP  = 64'h9e3779b97f4a7c15;
    localparam logic [DATA_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [DATA_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam logic [DATA_W-1:0] CHANCE_SCALE = 64'd1000000;

    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THR_START,
        ST_THR_WAIT,
        ST_ADV,
        ST_MUL,
        ST_XOR,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_FIN
    } t_state;

endpackage

@@ design/smbr_div.sv @@
// Serial restoring divider that returns the remainder, one quotient bit per cycle.
// Standalone; used by the top level for the threshold and the final modulo.
module smbr_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_rem
);

    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_dvd, n_dvd;
    logic [W-1:0]     r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [W:0]       w_trial;
    logic [W:0]       w_diff;

    assign w_trial = {r_rem, r_dvd[W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_dvd = {r_dvd[W-2:0], 1'b0};
        if (w_diff[W]) begin
            n_rem = w_trial[W-1:0];
        end else begin
            n_rem = w_diff[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/splitmix_bounded_random.sv @@
// Top level of the splitmix bounded random generator with rejection sampling.
// Depends on smbr_pkg and the serial divider smbr_div.
//
//   channel | handshake                  | payload
//   input   | i_in_valid / o_in_ready    | i_cmd, i_seed_value, i_bound, i_chance_ppm
//   output  | o_out_valid / i_out_ready  | o_draw, o_hit
//
// A reseed, an unused command or a bound below 2 goes from the finish state to the output register.
// A draw computes the threshold in the divider, then mixes raw draws (one 32x32 multiplier
// used three times per mixing product), then takes the final modulo in the divider.
// One item is in flight at a time; a finished result waits in the output register.
// Reset is synchronous and active low and clears the counter and all control state.
module splitmix_bounded_random (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_seed_value,
    input  logic [63:0] i_bound,
    input  logic [19:0] i_chance_ppm,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_draw,
    output logic        o_hit
);

    localparam int DW = smbr_pkg::DATA_W;
    localparam int HW = smbr_pkg::HALF_W;

    smbr_pkg::t_state r_state, n_state;

    logic [DW-1:0]              r_ctr, n_ctr;
    logic [DW-1:0]              r_z, n_z;
    logic [DW-1:0]              r_acc, n_acc;
    logic [DW-1:0]              r_thr, n_thr;
    logic [DW-1:0]              r_bound, n_bound;
    logic [DW-1:0]              r_res, n_res;
    logic [smbr_pkg::PPM_W-1:0] r_chance, n_chance;
    logic                       r_is_chance, n_is_chance;
    logic                       r_res_hit, n_res_hit;
    logic [1:0]                 r_ph, n_ph;
    logic                       r_round, n_round;
    logic                       r_out_valid, n_out_valid;
    logic [DW-1:0]              r_draw, n_draw;
    logic                       r_hit, n_hit;

    logic          w_accept;
    logic          w_slot_free;
    logic          w_div_start;
    logic [DW-1:0] w_div_dividend;
    logic          w_div_busy;
    logic          w_div_done;
    logic [DW-1:0] w_div_rem;
    logic [DW-1:0] w_k;
    logic [HW-1:0] w_mul_a, w_mul_b;
    logic [DW-1:0] w_prod;
    logic [DW-1:0] w_ctr_step;
    logic          w_small;

    assign o_in_ready  = (r_state == smbr_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_small     = (i_cmd == smbr_pkg::CMD_DRAW) && (i_bound < 64'd2);

    assign w_k     = r_round ? smbr_pkg::MIX_MUL_B : smbr_pkg::MIX_MUL_A;
    assign w_mul_a = (r_ph == 2'd1) ? r_z[DW-1:HW] : r_z[HW-1:0];
    assign w_mul_b = (r_ph == 2'd2) ? w_k[DW-1:HW] : w_k[HW-1:0];
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_ctr_step = r_ctr + smbr_pkg::GOLDEN_STEP;

    smbr_div #(
        .W(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_bound),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            smbr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if ((i_cmd == smbr_pkg::CMD_DRAW && !w_small) ||
                        i_cmd == smbr_pkg::CMD_CHANCE) begin
                        n_state = smbr_pkg::ST_THR_START;
                    end else begin
                        n_state = smbr_pkg::ST_FIN;
                    end
                end
            end
            smbr_pkg::ST_THR_START: n_state = smbr_pkg::ST_THR_WAIT;
            smbr_pkg::ST_THR_WAIT: begin
                if (w_div_done) begin
                    n_state = smbr_pkg::ST_ADV;
                end
            end
            smbr_pkg::ST_ADV: n_state = smbr_pkg::ST_MUL;
            smbr_pkg::ST_MUL: begin
                if (r_ph == 2'd2) begin
                    n_state = smbr_pkg::ST_XOR;
                end
            end
            smbr_pkg::ST_XOR: begin
                n_state = r_round ? smbr_pkg::ST_CHECK : smbr_pkg::ST_MUL;
            end
            smbr_pkg::ST_CHECK: begin
                n_state = (r_z < r_thr) ? smbr_pkg::ST_ADV : smbr_pkg::ST_MOD_WAIT;
            end
            smbr_pkg::ST_MOD_WAIT: begin
                if (w_div_done) begin
                    n_state = smbr_pkg::ST_FIN;
                end
            end
            smbr_pkg::ST_FIN: begin
                if (w_slot_free) begin
                    n_state = smbr_pkg::ST_IDLE;
                end
            end
            default: n_state = smbr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_ctr          = r_ctr;
        n_z            = r_z;
        n_acc          = r_acc;
        n_thr          = r_thr;
        n_bound        = r_bound;
        n_res          = r_res;
        n_chance       = r_chance;
        n_is_chance    = r_is_chance;
        n_res_hit      = r_res_hit;
        n_ph           = r_ph;
        n_round        = r_round;
        w_div_start    = 1'b0;
        w_div_dividend = '0 - r_bound;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_draw         = r_draw;
        n_hit          = r_hit;
        case (r_state)
            smbr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res       = '0;
                    n_res_hit   = 1'b0;
                    n_chance    = i_chance_ppm;
                    n_is_chance = (i_cmd == smbr_pkg::CMD_CHANCE);
                    n_bound     = (i_cmd == smbr_pkg::CMD_CHANCE) ?
                                  smbr_pkg::CHANCE_SCALE : i_bound;
                    if (i_cmd == smbr_pkg::CMD_RESEED) begin
                        n_ctr = i_seed_value;
                    end
                end
            end
            smbr_pkg::ST_THR_START: begin
                w_div_start = 1'b1;
            end
            smbr_pkg::ST_THR_WAIT: begin
                if (w_div_done) begin
                    n_thr = w_div_rem;
                end
            end
            smbr_pkg::ST_ADV: begin
                n_ctr   = w_ctr_step;
                n_z     = w_ctr_step ^ (w_ctr_step >> smbr_pkg::MIX_SHIFT_A);
                n_ph    = 2'd0;
                n_round = 1'b0;
            end
            smbr_pkg::ST_MUL: begin
                if (r_ph == 2'd0) begin
                    n_acc = w_prod;
                end else begin
                    n_acc = r_acc + {w_prod[HW-1:0], {HW{1'b0}}};
                end
                n_ph = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
            end
            smbr_pkg::ST_XOR: begin
                if (r_round) begin
                    n_z = r_acc ^ (r_acc >> smbr_pkg::MIX_SHIFT_C);
                end else begin
                    n_z = r_acc ^ (r_acc >> smbr_pkg::MIX_SHIFT_B);
                end
                n_round = 1'b1;
            end
            smbr_pkg::ST_CHECK: begin
                w_div_dividend = r_z;
                w_div_start    = !(r_z < r_thr);
            end
            smbr_pkg::ST_MOD_WAIT: begin
                if (w_div_done) begin
                    n_res     = w_div_rem;
                    n_res_hit = r_is_chance &&
                                (w_div_rem < {{(DW - smbr_pkg::PPM_W){1'b0}}, r_chance});
                end
            end
            smbr_pkg::ST_FIN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_draw      = r_res;
                    n_hit       = r_res_hit;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smbr_pkg::ST_IDLE;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
            r_ph        <= 2'd0;
            r_round     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctr       <= n_ctr;
            r_out_valid <= n_out_valid;
            r_ph        <= n_ph;
            r_round     <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z         <= n_z;
        r_acc       <= n_acc;
        r_thr       <= n_thr;
        r_bound     <= n_bound;
        r_res       <= n_res;
        r_chance    <= n_chance;
        r_is_chance <= n_is_chance;
        r_res_hit   <= n_res_hit;
        r_draw      <= n_draw;
        r_hit       <= n_hit;
    end

    assign o_out_valid = r_out_valid;
    assign o_draw      = r_draw;
    assign o_hit       = r_hit;

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smbr_pkg::ST_IDLE) |-> !w_div_busy)
        else $error("Divider busy while the sequencer is idle.");

    a_thr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smbr_pkg::ST_THR_START) |-> (r_bound >= 64'd2))
        else $error("Threshold division started with a bound below two.");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smbr_pkg::ST_MOD_WAIT && w_div_done) |-> (w_div_rem < r_bound))
        else $error("Final remainder is not below the bound.");

    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_draw < smbr_pkg::CHANCE_SCALE))
        else $error("Hit beat carries a draw outside the chance scale.");

endmodule
